FILE: src/cqf_pkg.sv
// cqf_pkg: shared types and codes for the circular queue fifo
// operation and status codes, item structs, controller/datapath command and status
// no dependencies
`default_nettype none

package cqf_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SLOT_W   = 5;
  localparam int unsigned COUNT_W  = 5;

  localparam logic [OP_W-1:0] OP_ENQ = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQ = 2'd1;
  localparam logic [OP_W-1:0] OP_DSP = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic signed [WORD_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [WORD_W-1:0] data;
    logic [SLOT_W-1:0]        slot;
    logic [COUNT_W-1:0]       count;
    logic                     last;
  } out_item_t;

  typedef enum logic [2:0] {
    EK_FULL,
    EK_EMPTY,
    EK_ENQ_OK,
    EK_DEQ_WORD,
    EK_DSP_WORD
  } emit_kind_e;

  typedef struct packed {
    logic       capture;
    logic       enq_write;
    logic       deq_adv;
    logic       rd_en;
    logic       rd_disp;
    logic       disp_start;
    logic       disp_step;
    logic       emit;
    emit_kind_e emit_kind;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            empty;
    logic            full;
    logic            disp_last;
    logic            out_free;
  } sts_t;

endpackage

`default_nettype wire

FILE: src/cqf_dp.sv
// cqf_dp: datapath of the circular queue fifo
// word memory, head/tail/count pointers, display walker, input and output registers
// depends on cqf_pkg
`default_nettype none

module cqf_dp #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cqf_pkg::in_item_t in_item_i,
  input  wire logic             out_ready_i,
  input  wire cqf_pkg::cmd_t    cmd_i,
  output cqf_pkg::sts_t         sts_o,
  output logic                  out_valid_o,
  output cqf_pkg::out_item_t    out_item_o
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SXW = (IW + 1 > cqf_pkg::SLOT_W) ? IW + 1 : cqf_pkg::SLOT_W;
  localparam int unsigned CXW = (CW > cqf_pkg::COUNT_W) ? CW : cqf_pkg::COUNT_W;

  logic signed [cqf_pkg::WORD_W-1:0] mem [DEPTH];

  logic [cqf_pkg::OP_W-1:0]          op_q;
  logic signed [cqf_pkg::WORD_W-1:0] value_q;
  logic [IW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CW-1:0] count_q, count_d;
  logic          empty_q, empty_d;
  logic [IW-1:0] disp_idx_q, disp_idx_d;
  logic [CW-1:0] disp_cnt_q, disp_cnt_d;
  logic signed [cqf_pkg::WORD_W-1:0] rd_data_q;
  logic          out_valid_q;
  cqf_pkg::out_item_t out_item_q;

  logic [IW-1:0] head_nxt, tail_nxt, disp_nxt, wr_addr, rd_addr;
  logic          full, disp_last, out_free;
  logic [SXW-1:0] slot_ext;
  logic [CXW-1:0] count_ext;
  logic [CW-1:0]  count_res;
  cqf_pkg::out_item_t res;

  assign head_nxt = (head_q == IW'(DEPTH - 1)) ? '0 : head_q + IW'(1);
  assign tail_nxt = (tail_q == IW'(DEPTH - 1)) ? '0 : tail_q + IW'(1);
  assign disp_nxt = (disp_idx_q == IW'(DEPTH - 1)) ? '0 : disp_idx_q + IW'(1);
  assign wr_addr  = empty_q ? '0 : tail_nxt;
  assign rd_addr  = cmd_i.rd_disp ? disp_idx_q : head_q;

  assign full      = (count_q == CW'(DEPTH));
  assign disp_last = ((disp_cnt_q + CW'(1)) == count_q);
  assign out_free  = !out_valid_q || out_ready_i;

  assign sts_o.op        = op_q;
  assign sts_o.empty     = empty_q;
  assign sts_o.full      = full;
  assign sts_o.disp_last = disp_last;
  assign sts_o.out_free  = out_free;

  // word memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.enq_write) begin
      mem[wr_addr] <= value_q;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // queue pointers
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    empty_d = empty_q;
    if (cmd_i.enq_write) begin
      if (empty_q) begin
        head_d = '0;
        tail_d = '0;
      end else begin
        tail_d = tail_nxt;
      end
      empty_d = 1'b0;
      count_d = count_q + CW'(1);
    end else if (cmd_i.deq_adv) begin
      if (head_q == tail_q) begin
        head_d  = '0;
        tail_d  = '0;
        empty_d = 1'b1;
      end else begin
        head_d = head_nxt;
      end
      count_d = count_q - CW'(1);
    end
  end

  always_comb begin
    disp_idx_d = disp_idx_q;
    disp_cnt_d = disp_cnt_q;
    if (cmd_i.disp_start) begin
      disp_idx_d = head_q;
      disp_cnt_d = '0;
    end else if (cmd_i.disp_step) begin
      disp_idx_d = disp_nxt;
      disp_cnt_d = disp_cnt_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      tail_q     <= '0;
      count_q    <= '0;
      empty_q    <= 1'b1;
      disp_idx_q <= '0;
      disp_cnt_q <= '0;
    end else begin
      head_q     <= head_d;
      tail_q     <= tail_d;
      count_q    <= count_d;
      empty_q    <= empty_d;
      disp_idx_q <= disp_idx_d;
      disp_cnt_q <= disp_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= in_item_i.operation;
      value_q <= in_item_i.value;
    end
  end

  // result formatting
  assign count_res = (cmd_i.emit_kind == cqf_pkg::EK_ENQ_OK) ? count_q + CW'(1) : count_q;
  assign slot_ext  = SXW'(disp_idx_q) + SXW'(1);
  assign count_ext = CXW'(count_res);

  always_comb begin
    res.status = cqf_pkg::ST_OK;
    res.data   = '0;
    res.slot   = '0;
    res.count  = count_ext[cqf_pkg::COUNT_W-1:0];
    res.last   = 1'b1;
    case (cmd_i.emit_kind)
      cqf_pkg::EK_FULL: begin
        res.status = cqf_pkg::ST_FULL;
      end
      cqf_pkg::EK_EMPTY: begin
        res.status = cqf_pkg::ST_EMPTY;
        res.count  = '0;
      end
      cqf_pkg::EK_DEQ_WORD: begin
        res.data = rd_data_q;
      end
      cqf_pkg::EK_DSP_WORD: begin
        res.data = rd_data_q;
        res.slot = slot_ext[cqf_pkg::SLOT_W-1:0];
        res.last = disp_last;
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("stored count exceeds depth");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_q == (count_q == '0))
    else $error("empty flag disagrees with count");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> out_free)
    else $error("result overwrites an item not yet taken");

  a_enq_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.enq_write |-> !full)
    else $error("write into a full queue");

  a_enq_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.enq_write |=> !empty_q)
    else $error("queue empty after a write");

endmodule

`default_nettype wire

FILE: src/cqf_ctrl.sv
// cqf_ctrl: controller state machine of the circular queue fifo
// sequences capture, memory access and result emission; drives cqf_dp commands
// depends on cqf_pkg
`default_nettype none

module cqf_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire cqf_pkg::sts_t sts_i,
  output cqf_pkg::cmd_t      cmd_o
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_EXEC    = 3'd1;
  localparam logic [2:0] S_DEQ_OUT = 3'd2;
  localparam logic [2:0] S_DSP_RD  = 3'd3;
  localparam logic [2:0] S_DSP_OUT = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.emit_kind = cqf_pkg::EK_EMPTY;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (sts_i.op) inside
          cqf_pkg::OP_ENQ: begin
            if (sts_i.out_free) begin
              cmd_o.emit = 1'b1;
              if (sts_i.full) begin
                cmd_o.emit_kind = cqf_pkg::EK_FULL;
              end else begin
                cmd_o.emit_kind = cqf_pkg::EK_ENQ_OK;
                cmd_o.enq_write = 1'b1;
              end
              state_d = S_IDLE;
            end
          end
          cqf_pkg::OP_DEQ, cqf_pkg::OP_DSP: begin
            if (sts_i.empty) begin
              if (sts_i.out_free) begin
                cmd_o.emit      = 1'b1;
                cmd_o.emit_kind = cqf_pkg::EK_EMPTY;
                state_d         = S_IDLE;
              end
            end else if (sts_i.op == cqf_pkg::OP_DEQ) begin
              cmd_o.rd_en   = 1'b1;
              cmd_o.deq_adv = 1'b1;
              state_d       = S_DEQ_OUT;
            end else begin
              cmd_o.disp_start = 1'b1;
              state_d          = S_DSP_RD;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_DEQ_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = cqf_pkg::EK_DEQ_WORD;
          state_d         = S_IDLE;
        end
      end
      S_DSP_RD: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_disp = 1'b1;
        state_d       = S_DSP_OUT;
      end
      S_DSP_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = cqf_pkg::EK_DSP_WORD;
          if (sts_i.disp_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.disp_step = 1'b1;
            state_d         = S_DSP_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_EXEC))
    else $error("accepted item not executed");

  a_dsp_read_then_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DSP_RD) |=> (state_q == S_DSP_OUT))
    else $error("display read not followed by emission");

  a_single_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.enq_write && cmd_o.rd_en))
    else $error("memory written and read in one cycle");

endmodule

`default_nettype wire

FILE: src/circular_queue_fifo.sv
// Ring-buffer fifo of DEPTH signed 32-bit words. Each input item is an enqueue,
// a dequeue or a display of all stored words (oldest first, one result each).
// One item is handled at a time: the input is ready only while the controller
// is idle. A dequeue reads the word memory through its registered read port, and
// a display does one memory read plus one emission per stored word. A finished
// result sits in an output register; emission waits while the consumer holds
// out_ready_i low and the previous result is not yet taken. Count and slot are
// reported modulo 32. Unused operation codes give no result.
// depends on cqf_pkg, cqf_ctrl, cqf_dp
`default_nettype none

module circular_queue_fifo #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire cqf_pkg::in_item_t in_item_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output cqf_pkg::out_item_t     out_item_o
);

  cqf_pkg::cmd_t cmd;
  cqf_pkg::sts_t sts;

  cqf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cqf_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire
